### hdl/mt19937_generator_macros.svh
// Assertion macros used by the generator's control module.
`ifndef MT19937_GENERATOR_MACROS_SVH
`define MT19937_GENERATOR_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define MTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the following cycle.
`define MTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mtg_pkg.sv
`default_nettype none
package mtg_pkg;

  localparam int unsigned N = 624;
  localparam int unsigned M = 397;
  localparam int unsigned AW = 10;

  localparam logic [31:0] TWIST_MAT  = 32'h9908_b0df;
  localparam logic [31:0] C_INIT     = 32'd1812433253;
  localparam logic [31:0] C_KEY_A    = 32'd1664525;
  localparam logic [31:0] C_KEY_B    = 32'd1566083941;
  localparam logic [31:0] SEED_KEY   = 32'd19650218;
  localparam logic [31:0] SEED_DEF   = 32'd5489;
  localparam logic [31:0] WORD0_KEY  = 32'h8000_0000;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

  localparam logic [AW-1:0] IDX_USED   = AW'(N);
  localparam logic [AW-1:0] IDX_LAST   = AW'(N - 1);

  typedef enum logic [1:0] {
    ACT_DRAW = 2'd0,
    ACT_SEED = 2'd1,
    ACT_KEY  = 2'd2,
    ACT_RSVD = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S1_MUL,
    ST_S1_ADD,
    ST_K_RD,
    ST_K_WR,
    ST_K_WRAP,
    ST_K_FIN,
    ST_TW_PRE,
    ST_TWIST,
    ST_TW_END,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_KEY,
    AFT_TWIST
  } after_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [31:0]   data;
  } mem_wr_t;

  typedef struct packed {
    logic        load;
    logic [31:0] word;
  } draw_t;

  function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] far);
    logic [31:0] y;
    y = {a[31], b[30:0]};
    return far ^ (y >> 1) ^ (y[0] ? TWIST_MAT : 32'd0);
  endfunction

endpackage
`default_nettype wire

### hdl/mtg_state_ram.sv
`default_nettype none
module mtg_state_ram (
  input  wire logic                    clk,
  input  wire mtg_pkg::mem_wr_t        wr,
  input  wire logic [mtg_pkg::AW-1:0]  ra_a,
  input  wire logic [mtg_pkg::AW-1:0]  ra_b,
  output logic      [31:0]             rd_a,
  output logic      [31:0]             rd_b
);
  import mtg_pkg::*;

  logic [31:0] mem [N];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end
endmodule
`default_nettype wire

### hdl/mtg_key_ram.sv
`default_nettype none
module mtg_key_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned KW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [KW-1:0] wa,
  input  wire logic [31:0]   wd,
  input  wire logic [KW-1:0] ra,
  output logic      [31:0]   rd
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule
`default_nettype wire

### hdl/mtg_ctrl.sv
`default_nettype none
`include "mt19937_generator_macros.svh"
module mtg_ctrl #(
  parameter int unsigned KEY_MAX = 16,
  parameter int unsigned KW      = 4,
  parameter int unsigned CW      = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_action,
  input  wire logic [31:0]             in_seed_value,
  input  wire logic [31:0]             in_key_word,
  input  wire logic                    in_last_key,
  input  wire logic                    out_free,
  output mtg_pkg::draw_t               draw,
  output mtg_pkg::mem_wr_t             st_wr,
  output logic [mtg_pkg::AW-1:0]       st_ra_a,
  output logic [mtg_pkg::AW-1:0]       st_ra_b,
  input  wire logic [31:0]             st_rd_a,
  input  wire logic [31:0]             st_rd_b,
  output logic                         key_we,
  output logic [KW-1:0]                key_wa,
  output logic [31:0]                  key_wd,
  output logic [KW-1:0]                key_ra,
  input  wire logic [31:0]             key_rd
);
  import mtg_pkg::*;

  ctrl_state_t st_r, st_nxt;
  after_t      after_r, after_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] tk_r, tk_nxt;
  logic [AW-1:0] wk_r, wk_nxt;
  logic          wv_r, wv_nxt;
  logic          ldcur_r, ldcur_nxt;
  logic          phase_r, phase_nxt;
  logic [KW-1:0] j_r, j_nxt;
  logic [CW-1:0] key_count_r, key_count_nxt;
  logic [31:0]   p_r, p_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   mul_a, mul_k, w_key;
  logic          j_last;

  assign mul_a  = p_r ^ (p_r >> 30);
  assign j_last = (CW'(j_r) + CW'(1)) == key_count_r;
  assign w_key  = phase_r ? ((st_rd_a ^ prod_r) - 32'(i_r))
                          : ((st_rd_a ^ prod_r) + key_rd + 32'(j_r));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_DRAW: begin
              if (idx_r < IDX_USED) begin
                st_nxt = out_free ? ST_DRAW_OUT : ST_DRAW_RD;
              end else if (idx_r == IDX_USED) begin
                st_nxt = ST_TW_PRE;
              end else begin
                st_nxt = ST_S1_MUL;
              end
            end
            ACT_SEED: st_nxt = ST_S1_MUL;
            ACT_KEY:  st_nxt = in_last_key ? ST_S1_MUL : ST_IDLE;
            default:  st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_S1_MUL: st_nxt = ST_S1_ADD;
      ST_S1_ADD: begin
        if (i_r == IDX_LAST) begin
          case (after_r)
            AFT_KEY:   st_nxt = ST_K_RD;
            AFT_TWIST: st_nxt = ST_TW_PRE;
            default:   st_nxt = ST_IDLE;
          endcase
        end else begin
          st_nxt = ST_S1_MUL;
        end
      end
      ST_K_RD: st_nxt = ST_K_WR;
      ST_K_WR: begin
        if (i_r == IDX_LAST) begin
          st_nxt = ST_K_WRAP;
        end else if (k_r == AW'(1) && phase_r) begin
          st_nxt = ST_K_FIN;
        end else begin
          st_nxt = ST_K_RD;
        end
      end
      ST_K_WRAP: st_nxt = (k_r == '0 && phase_r) ? ST_K_FIN : ST_K_RD;
      ST_K_FIN:  st_nxt = ST_IDLE;
      ST_TW_PRE: st_nxt = ST_TWIST;
      ST_TWIST:  st_nxt = (tk_r == IDX_LAST) ? ST_TW_END : ST_TWIST;
      ST_TW_END: st_nxt = ST_DRAW_RD;
      ST_DRAW_RD: st_nxt = out_free ? ST_DRAW_OUT : ST_DRAW_RD;
      ST_DRAW_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    after_nxt     = after_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    tk_nxt        = tk_r;
    wk_nxt        = wk_r;
    wv_nxt        = wv_r;
    ldcur_nxt     = 1'b0;
    phase_nxt     = phase_r;
    j_nxt         = j_r;
    key_count_nxt = key_count_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    mul_k         = C_INIT;
    in_ready      = (st_r == ST_IDLE);
    draw.load     = 1'b0;
    draw.word     = st_rd_a;
    st_wr.en      = 1'b0;
    st_wr.addr    = i_r;
    st_wr.data    = w_key;
    st_ra_a       = i_r;
    st_ra_b       = '0;
    key_we        = 1'b0;
    key_wa        = key_count_r[KW-1:0];
    key_wd        = in_key_word;
    key_ra        = j_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_DRAW: begin
              if (idx_r < IDX_USED) begin
                if (out_free) begin
                  st_ra_a = idx_r;
                  idx_nxt = idx_r + AW'(1);
                end
              end else if (idx_r != IDX_USED) begin
                // Never seeded: the default seed comes first, then the twist.
                st_wr.en   = 1'b1;
                st_wr.addr = '0;
                st_wr.data = SEED_DEF;
                p_nxt      = SEED_DEF;
                i_nxt      = AW'(1);
                after_nxt  = AFT_TWIST;
              end
            end
            ACT_SEED: begin
              st_wr.en   = 1'b1;
              st_wr.addr = '0;
              st_wr.data = in_seed_value;
              p_nxt      = in_seed_value;
              i_nxt      = AW'(1);
              after_nxt  = AFT_IDLE;
            end
            ACT_KEY: begin
              if (key_count_r < CW'(KEY_MAX)) begin
                key_we        = 1'b1;
                key_count_nxt = key_count_r + CW'(1);
              end
              if (in_last_key) begin
                st_wr.en   = 1'b1;
                st_wr.addr = '0;
                st_wr.data = SEED_KEY;
                p_nxt      = SEED_KEY;
                i_nxt      = AW'(1);
                after_nxt  = AFT_KEY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_S1_MUL: begin
        prod_nxt = mul_a * mul_k;
      end
      ST_S1_ADD: begin
        st_wr.en   = 1'b1;
        st_wr.data = prod_r + 32'(i_r);
        p_nxt      = prod_r + 32'(i_r);
        if (i_r == IDX_LAST) begin
          idx_nxt = IDX_USED;
          if (after_r == AFT_KEY) begin
            p_nxt     = SEED_KEY;
            i_nxt     = AW'(1);
            j_nxt     = '0;
            k_nxt     = IDX_USED;
            phase_nxt = 1'b0;
          end
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      ST_K_RD: begin
        mul_k    = phase_r ? C_KEY_B : C_KEY_A;
        prod_nxt = mul_a * mul_k;
      end
      ST_K_WR: begin
        st_wr.en = 1'b1;
        p_nxt    = w_key;
        k_nxt    = k_r - AW'(1);
        if (!phase_r) begin
          j_nxt = j_last ? '0 : j_r + KW'(1);
        end
        if (i_r == IDX_LAST) begin
          i_nxt = AW'(1);
        end else begin
          i_nxt = i_r + AW'(1);
          if (k_r == AW'(1) && !phase_r) begin
            phase_nxt = 1'b1;
            k_nxt     = IDX_LAST;
          end
        end
      end
      ST_K_WRAP: begin
        // Word 0 takes a copy of the last word so the walk can start over.
        st_wr.en   = 1'b1;
        st_wr.addr = '0;
        st_wr.data = p_r;
        if (k_r == '0 && !phase_r) begin
          phase_nxt = 1'b1;
          k_nxt     = IDX_LAST;
        end
      end
      ST_K_FIN: begin
        st_wr.en      = 1'b1;
        st_wr.addr    = '0;
        st_wr.data    = WORD0_KEY;
        idx_nxt       = IDX_USED;
        key_count_nxt = '0;
      end
      ST_TW_PRE: begin
        st_ra_a   = '0;
        tk_nxt    = '0;
        wv_nxt    = 1'b0;
        ldcur_nxt = 1'b1;
      end
      ST_TWIST: begin
        // Reads for word tk are issued while word tk-1 is written back.
        st_ra_a = (tk_r == IDX_LAST) ? '0 : tk_r + AW'(1);
        st_ra_b = (tk_r < AW'(N - M)) ? tk_r + AW'(M) : tk_r - AW'(N - M);
        wv_nxt  = 1'b1;
        wk_nxt  = tk_r;
        tk_nxt  = tk_r + AW'(1);
        if (ldcur_r) begin
          cur_nxt = st_rd_a;
        end
        if (wv_r) begin
          st_wr.en   = 1'b1;
          st_wr.addr = wk_r;
          st_wr.data = mix(cur_r, st_rd_a, st_rd_b);
          cur_nxt    = st_rd_a;
        end
      end
      ST_TW_END: begin
        st_wr.en   = 1'b1;
        st_wr.addr = wk_r;
        st_wr.data = mix(cur_r, st_rd_a, st_rd_b);
        wv_nxt     = 1'b0;
        idx_nxt    = '0;
      end
      ST_DRAW_RD: begin
        if (out_free) begin
          st_ra_a = idx_r;
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_DRAW_OUT: begin
        draw.load = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      after_r     <= AFT_IDLE;
      idx_r       <= AW'(N + 1);
      key_count_r <= '0;
      wv_r        <= 1'b0;
      ldcur_r     <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      after_r     <= after_nxt;
      idx_r       <= idx_nxt;
      key_count_r <= key_count_nxt;
      wv_r        <= wv_nxt;
      ldcur_r     <= ldcur_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    tk_r   <= tk_nxt;
    wk_r   <= wk_nxt;
    j_r    <= j_nxt;
    p_r    <= p_nxt;
    prod_r <= prod_nxt;
    cur_r  <= cur_nxt;
  end

  `MTG_ASSERT_NOW(a_wr_addr, st_wr.en, st_wr.addr < IDX_USED, "state write beyond the store")
  `MTG_ASSERT_NOW(a_key_count, 1'b1, key_count_r <= CW'(KEY_MAX), "key count overran")
  `MTG_ASSERT_NOW(a_idx_range, 1'b1, idx_r <= AW'(N + 1), "word index out of range")
  `MTG_ASSERT_NEXT(a_load_free, st_r == ST_DRAW_OUT, st_r == ST_IDLE, "draw did not finish")
endmodule
`default_nettype wire

### hdl/mt19937_generator.sv
// Draw: while words remain and the output is free, the stored word is read, tempered and registered;
// the first draw after the store is used up first runs a twist over the whole store.
// The twist rewrites one word per cycle; a new request is taken only once the block is idle again.
// Seeding from one value makes one pass over the store; key seeding adds two more passes.
// Reset is synchronous and active low; the block starts unseeded.
`default_nettype none
module mt19937_generator #(
  parameter int unsigned KEY_MAX = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_seed_value,
  input  wire logic [31:0] in_key_word,
  input  wire logic        in_last_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_random_word
);
  import mtg_pkg::*;

  localparam int unsigned KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned CW = $clog2(KEY_MAX + 1);

  draw_t         draw;
  mem_wr_t       st_wr;
  logic [AW-1:0] st_ra_a, st_ra_b;
  logic [31:0]   st_rd_a, st_rd_b;
  logic          key_we;
  logic [KW-1:0] key_wa, key_ra;
  logic [31:0]   key_wd, key_rd;
  logic          out_free;
  logic          out_valid_r;
  logic [31:0]   word_r, tempered;
  logic [31:0]   t1, t2, t3;

  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = word_r;

  always_comb begin
    t1       = draw.word ^ (draw.word >> 11);
    t2       = t1 ^ ((t1 << 7) & TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (draw.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw.load) begin
      word_r <= tempered;
    end
  end

  mtg_state_ram u_state_ram (
    .clk  (clk),
    .wr   (st_wr),
    .ra_a (st_ra_a),
    .ra_b (st_ra_b),
    .rd_a (st_rd_a),
    .rd_b (st_rd_b)
  );

  mtg_key_ram #(
    .DEPTH (KEY_MAX),
    .KW    (KW)
  ) u_key_ram (
    .clk (clk),
    .we  (key_we),
    .wa  (key_wa),
    .wd  (key_wd),
    .ra  (key_ra),
    .rd  (key_rd)
  );

  mtg_ctrl #(
    .KEY_MAX (KEY_MAX),
    .KW      (KW),
    .CW      (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_seed_value (in_seed_value),
    .in_key_word   (in_key_word),
    .in_last_key   (in_last_key),
    .out_free      (out_free),
    .draw          (draw),
    .st_wr         (st_wr),
    .st_ra_a       (st_ra_a),
    .st_ra_b       (st_ra_b),
    .st_rd_a       (st_rd_a),
    .st_rd_b       (st_rd_b),
    .key_we        (key_we),
    .key_wa        (key_wa),
    .key_wd        (key_wd),
    .key_ra        (key_ra),
    .key_rd        (key_rd)
  );
endmodule
`default_nettype wire

### tb/tb_mt19937_generator.sv
`default_nettype none
module tb_mt19937_generator;
  import mtg_pkg::*;

  localparam int unsigned KEYS = 16;
  localparam int unsigned LIMIT = 4000000;

  // Expected tempered words in transfer order, with its own generator copy.
  class mt_scoreboard;
    logic [31:0] st [624];
    int unsigned idx;
    logic [31:0] keys [KEYS];
    int unsigned kcount;
    logic [31:0] pending [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      idx = 625;
      kcount = 0;
      errors = 0;
      checked = 0;
      foreach (st[i]) st[i] = '0;
      foreach (keys[i]) keys[i] = '0;
    endfunction

    function void init_one(logic [31:0] s);
      logic [31:0] p;
      st[0] = s;
      for (int i = 1; i < 624; i++) begin
        p = st[i-1];
        st[i] = C_INIT * (p ^ (p >> 30)) + 32'(i);
      end
      idx = 624;
    endfunction

    function void seed_from_key(int unsigned len);
      int unsigned i, j, k;
      logic [31:0] p;
      i = 1;
      j = 0;
      init_one(SEED_KEY);
      k = (624 > len) ? 624 : len;
      for (; k != 0; k--) begin
        p = st[i-1];
        st[i] = (st[i] ^ ((p ^ (p >> 30)) * C_KEY_A)) + keys[j] + 32'(j);
        i++;
        j++;
        if (i >= 624) begin
          st[0] = st[623];
          i = 1;
        end
        if (j >= len) j = 0;
      end
      for (k = 623; k != 0; k--) begin
        p = st[i-1];
        st[i] = (st[i] ^ ((p ^ (p >> 30)) * C_KEY_B)) - 32'(i);
        i++;
        if (i >= 624) begin
          st[0] = st[623];
          i = 1;
        end
      end
      st[0] = WORD0_KEY;
      idx = 624;
    endfunction

    function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] far);
      logic [31:0] y;
      y = {a[31], b[30:0]};
      return far ^ (y >> 1) ^ (y[0] ? TWIST_MAT : 32'd0);
    endfunction

    function logic [31:0] next_word();
      logic [31:0] y;
      if (idx >= 624) begin
        if (idx != 624) init_one(SEED_DEF);
        for (int k = 0; k < 623; k++)
          st[k] = blend(st[k], st[k+1], (k < 227) ? st[k+397] : st[k+397-624]);
        st[623] = blend(st[623], st[0], st[396]);
        idx = 0;
      end
      y = st[idx];
      idx++;
      y ^= y >> 11;
      y ^= (y << 7) & TEMPER_B;
      y ^= (y << 15) & TEMPER_C;
      y ^= y >> 18;
      return y;
    endfunction

    function void note_input(logic [1:0] act, logic [31:0] sv, logic [31:0] kw, logic last);
      if (act == ACT_DRAW) pending.push_back(next_word());
      else if (act == ACT_SEED) init_one(sv);
      else if (act == ACT_KEY) begin
        if (kcount < KEYS) begin
          keys[kcount] = kw;
          kcount++;
        end
        if (last) begin
          seed_from_key(kcount);
          kcount = 0;
        end
      end
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        $error("unexpected result: random_word actual %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $error("random_word mismatch: expected %h actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [31:0] in_seed_value = '0;
  logic [31:0] in_key_word = '0;
  logic in_last_key = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_random_word;

  mt_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  always #6 clk = ~clk;

  mt19937_generator #(.KEY_MAX(KEYS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_seed_value(in_seed_value),
    .in_key_word(in_key_word), .in_last_key(in_last_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_random_word(out_random_word)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_action, in_seed_value, in_key_word, in_last_key);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_random_word);
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Valid stays high between back-to-back items; it drops only for random idle gaps outside calm mode.
  task automatic send(logic [1:0] act, logic [31:0] sv, logic [31:0] kw, logic last);
    if (!calm) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_seed_value <= sv;
    in_key_word <= kw;
    in_last_key <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_key(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send(ACT_KEY, $urandom, $urandom, i == len - 1);
  endtask

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) send(ACT_DRAW, $urandom, $urandom, 1'($urandom_range(1)));
    else if (r < 84) send(ACT_SEED, $urandom, $urandom, 1'($urandom_range(1)));
    else if (r < 86) send_key($urandom_range(1, 20));
    else if (r < 90) send(ACT_KEY, $urandom, $urandom, 1'b0);
    else send(ACT_RSVD, $urandom, $urandom, 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unseeded first draw falls back to the default seed.
    send(ACT_DRAW, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send(ACT_DRAW, '0, '0, 1'b0);
    send(ACT_RSVD, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send(ACT_SEED, 32'h0, '0, 1'b0);
    send(ACT_DRAW, '0, '0, 1'b0);
    send(ACT_SEED, 32'hffff_ffff, '0, 1'b1);
    send(ACT_DRAW, '0, '0, 1'b0);
    // Single-word key, extreme values.
    send(ACT_KEY, '0, 32'hffff_ffff, 1'b1);
    send(ACT_DRAW, '0, '0, 1'b0);
    send(ACT_KEY, '0, 32'h0, 1'b1);
    send(ACT_DRAW, '0, '0, 1'b0);
    // Partial key survives a single-value seed, then overflows past the buffer.
    send(ACT_KEY, '0, 32'h1234_5678, 1'b0);
    send(ACT_SEED, 32'h5a5a_a5a5, '0, 1'b0);
    send_key(KEYS + 3);
    send(ACT_DRAW, '0, '0, 1'b0);

    // Long receiver hold-off while draws keep coming.
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 12; i++) send(ACT_DRAW, $urandom, $urandom, 1'b0);
        in_valid <= 1'b0;
      end
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    @(negedge clk);

    // Enough draws in one run to cross several twists.
    calm = 1'b1;
    for (int i = 0; i < 150; i++) random_item();
    calm = 1'b0;
    while (sent < 870) random_item();
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
    $display("Sent %0d items and checked %0d words, with seeding, key overflow",
             sent, sb.checked);
    $display("and a long output stall.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/mtg_pkg.sv
hdl/mtg_state_ram.sv
hdl/mtg_key_ram.sv
hdl/mtg_ctrl.sv
hdl/mt19937_generator.sv
tb/tb_mt19937_generator.sv
